### rtl/core/kmde_pkg.sv
// ----------------------------------------------------------------------------
// kmde_pkg
// Shared types and constants for the key matrix debounce encoder.
// ----------------------------------------------------------------------------
package kmde_pkg;

  localparam int ROWS  = 3;
  localparam int COLS  = 4;
  localparam int NKEYS = ROWS * COLS;

  localparam int QUEUE_DEPTH = 4;

  localparam int          REG_DEBOUNCE   = 0;
  localparam logic [15:0] DEBOUNCE_RESET = 16'd20;

  typedef struct packed {
    logic [31:0]      now_ms;
    logic [NKEYS-1:0] key_levels;
    logic             power_switch;
  } in_word_t;

  typedef struct packed {
    logic [7:0] event_code;
    logic       last_event;
  } out_word_t;

  // events found in one sample
  typedef struct packed {
    logic [NKEYS-1:0] key_mask;
    logic             sw_evt;
    logic             sw_lvl;
  } evt_t;

endpackage

### rtl/core/key_matrix_debounce_encoder_core.sv
// ----------------------------------------------------------------------------
// key_matrix_debounce_encoder_core
// Key matrix and power switch debouncer with event code output.
// ----------------------------------------------------------------------------
//  port group  direction  word / notes
//  in_*        sink       in_word_t: now_ms, key_levels, power_switch
//  out_*       source     out_word_t: event_code, last_event
//  cfg_*       APB        debounce_ms at every address (paddr not decoded)
//
//  A sample is taken every cycle while the event queue has room.
//  The back end sends one code per cycle while the output is not stalled,
//  so a sample with n events gives n codes and holds it until all are sent;
//  a sample with no event costs no queue entry. Synchronous reset; no clearing pass.
//  Output stall holds the output register; the front keeps taking samples
//  until QUEUE_DEPTH event masks wait.
// ----------------------------------------------------------------------------
module key_matrix_debounce_encoder_core #(
  parameter int QUEUE_DEPTH = kmde_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  kmde_pkg::in_word_t   in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output kmde_pkg::out_word_t  out_word,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [1:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);

  logic [15:0]    debounce_r;
  logic           push, pop, full, q_valid;
  kmde_pkg::evt_t push_evt, q_evt;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[1:0] == 2'(kmde_pkg::REG_DEBOUNCE)) ?
                      {16'd0, debounce_r} : {16'd0, debounce_r};
  assign in_stall   = full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= kmde_pkg::DEBOUNCE_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      debounce_r <= cfg_pwdata[15:0];
    end
  end

  kmde_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .debounce_ms (debounce_r),
    .push        (push),
    .push_evt    (push_evt)
  );

  kmde_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_evt (push_evt),
    .full     (full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_evt    (q_evt)
  );

  kmde_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_evt     (q_evt),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

### rtl/core/kmde_front.sv
// ----------------------------------------------------------------------------
// kmde_front
// Per-channel lockout debounce; turns one sample into an event mask.
// ----------------------------------------------------------------------------
module kmde_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  kmde_pkg::in_word_t   in_word,
  input  logic [15:0]          debounce_ms,
  output logic                 push,
  output kmde_pkg::evt_t       push_evt
);

  logic [kmde_pkg::NKEYS:0] level_r, level_nxt;
  logic [31:0]              time_r   [kmde_pkg::NKEYS+1];
  logic [kmde_pkg::NKEYS:0] take;
  logic [kmde_pkg::NKEYS:0] sample;
  logic                     accept;

  assign accept = in_valid && !in_stall;
  assign sample = {in_word.power_switch, in_word.key_levels};

  always_comb begin
    for (int i = 0; i <= kmde_pkg::NKEYS; i++) begin
      take[i] = (sample[i] != level_r[i]) &&
                ((in_word.now_ms - time_r[i]) > {16'd0, debounce_ms});
    end
    level_nxt = (level_r & ~take) | (sample & take);
    push_evt.key_mask = take[kmde_pkg::NKEYS-1:0] & sample[kmde_pkg::NKEYS-1:0];
    push_evt.sw_evt   = take[kmde_pkg::NKEYS];
    push_evt.sw_lvl   = sample[kmde_pkg::NKEYS];
    push = accept && ((|push_evt.key_mask) || push_evt.sw_evt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
      for (int i = 0; i <= kmde_pkg::NKEYS; i++) time_r[i] <= '0;
    end else if (accept) begin
      level_r <= level_nxt;
      for (int i = 0; i <= kmde_pkg::NKEYS; i++) begin
        if (take[i]) time_r[i] <= in_word.now_ms;
      end
    end
  end

endmodule

### rtl/core/kmde_queue.sv
// ----------------------------------------------------------------------------
// kmde_queue
// Short FIFO of event masks between front and back.
// ----------------------------------------------------------------------------
module kmde_queue #(
  parameter int DEPTH = kmde_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  kmde_pkg::evt_t  push_evt,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output kmde_pkg::evt_t  q_evt
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  kmde_pkg::evt_t mem [DEPTH];
  logic [PW-1:0]  wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  assign full    = (cnt_r == CW'(DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_evt   = mem[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    if (pop)  rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_r] <= push_evt;
  end

endmodule

### rtl/core/kmde_back.sv
// ----------------------------------------------------------------------------
// kmde_back
// Serializes one event mask into codes, one word per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module kmde_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  kmde_pkg::evt_t       q_evt,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output kmde_pkg::out_word_t  out_word
);

  kmde_pkg::evt_t      cur_r, cur_nxt, rest;
  logic                out_valid_r, out_valid_nxt;
  kmde_pkg::out_word_t out_word_r, out_word_nxt;
  logic                busy, emit, found;
  logic [7:0]          code;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    busy  = (|cur_r.key_mask) || cur_r.sw_evt;
    emit  = busy && (!out_valid_r || !out_stall);
    rest  = cur_r;
    found = 1'b0;
    code  = {7'd0, cur_r.sw_lvl};
    for (int r = 0; r < kmde_pkg::ROWS; r++) begin
      for (int c = 0; c < kmde_pkg::COLS; c++) begin
        if (!found && cur_r.key_mask[r*kmde_pkg::COLS+c]) begin
          found = 1'b1;
          code  = 8'(((r + 1) << 4) + c);
          rest.key_mask[r*kmde_pkg::COLS+c] = 1'b0;
        end
      end
    end
    if (!found) rest.sw_evt = 1'b0;

    out_word_nxt.event_code = code;
    out_word_nxt.last_event = !((|rest.key_mask) || rest.sw_evt);

    if (emit) out_valid_nxt = 1'b1;
    else      out_valid_nxt = out_valid_r && out_stall;

    cur_nxt = emit ? rest : cur_r;
    pop     = q_valid && !((|cur_nxt.key_mask) || cur_nxt.sw_evt);
    if (pop) cur_nxt = q_evt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cur_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      cur_r       <= cur_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_word_r <= out_word_nxt;
  end

endmodule

### rtl/core/kmde_checker.sv
// ----------------------------------------------------------------------------
// kmde_checker
// Port-level checks for the key matrix debounce encoder.
// ----------------------------------------------------------------------------
module kmde_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_stall,
  input kmde_pkg::out_word_t  out_word,
  input logic                 cfg_psel,
  input logic                 cfg_penable,
  input logic                 cfg_pwrite,
  input logic [31:0]          cfg_pwdata,
  input logic [31:0]          cfg_prdata,
  input logic                 cfg_pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("output word changed under stall");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_code_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.event_code[7:1] == 7'd0) ||
                  (out_word.event_code[7:4] >= 4'd1 &&
                   out_word.event_code[7:4] <= 4'(kmde_pkg::ROWS) &&
                   out_word.event_code[3:0] <  4'(kmde_pkg::COLS)))
    else $error("illegal event code");

  a_switch_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.event_code[7:1] == 7'd0 |-> out_word.last_event)
    else $error("switch event not last of its sample");

  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable && cfg_pwrite && cfg_pready |=>
      cfg_prdata[15:0] == $past(cfg_pwdata[15:0]))
    else $error("debounce register readback mismatch");

endmodule

bind key_matrix_debounce_encoder_core kmde_checker u_kmde_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_word    (out_word),
  .cfg_psel    (cfg_psel),
  .cfg_penable (cfg_penable),
  .cfg_pwrite  (cfg_pwrite),
  .cfg_pwdata  (cfg_pwdata),
  .cfg_prdata  (cfg_prdata),
  .cfg_pready  (cfg_pready)
);
